// ----- src/kms_pkg.sv -----
package kms_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 4;

  typedef logic [1:0] row_idx_t;
  typedef logic [1:0] col_idx_t;
  typedef logic [3:0] lines_t;
  typedef logic [6:0] ascii_t;

  // key map, indexed by {row, column}
  localparam ascii_t KEY_MAP [ROWS*COLS] = '{
    7'h37, 7'h38, 7'h39, 7'h2F,
    7'h34, 7'h35, 7'h36, 7'h58,
    7'h31, 7'h32, 7'h33, 7'h2D,
    7'h43, 7'h30, 7'h3D, 7'h2B
  };

  localparam logic [15:0] DEBOUNCE_RESET = 16'd10000;

  typedef struct packed {
    logic   valid;
    lines_t column_lines;
  } kms_stage_t;

  function automatic col_idx_t first_low(input lines_t column_lines);
    lines_t low;
    col_idx_t c;
    low = ~column_lines;
    if (low[0]) begin
      c = 2'd0;
    end else if (low[1]) begin
      c = 2'd1;
    end else if (low[2]) begin
      c = 2'd2;
    end else begin
      c = 2'd3;
    end
    return c;
  endfunction

endpackage

// ----- src/kms_if.sv -----
interface kms_in_if;
  import kms_pkg::*;
  logic   valid;
  logic   ready;
  lines_t column_lines;
  modport source (output valid, output column_lines, input ready);
  modport sink (input valid, input column_lines, output ready);
endinterface

interface kms_out_if;
  import kms_pkg::*;
  logic       valid;
  logic       ready;
  lines_t     row_drive;
  logic       key_valid;
  ascii_t     key_code;
  logic [7:0] press_count;
  logic       new_run;
  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output press_count, output new_run, input ready);
  modport sink (input valid, input row_drive, input key_valid, input key_code,
                input press_count, input new_run, output ready);
endinterface

interface kms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/matrix_keypad_scanner.sv -----
// Channel   Dir  Payload                                            Transaction when
// scan_in   in   column_lines[3:0]                                  valid && ready
// scan_out  out  row_drive, key_valid, key_code, press_count, new_run valid && ready
// cfg       in   data[15:0] = debounce_ticks                        valid && ready
//
// One scan tick per input transaction, one result per tick; a new tick can be taken
// every cycle while the result side is not stalling. The path is the input register,
// then the scan state update and the result register in the same edge.
// rst is synchronous: row 0, scanning, no previous key, debounce_ticks = 10000.
// A held result stalls the input register; scan_in.ready drops only when both are full.
module matrix_keypad_scanner #(
  parameter int COUNT_WIDTH    = 8,
  parameter int DEBOUNCE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  kms_in_if.sink     scan_in,
  kms_out_if.source  scan_out,
  kms_cfg_if.sink    cfg
);
  import kms_pkg::*;

  kms_stage_t stage;
  logic       stage_ready;

  kms_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .scan_in     (scan_in),
    .stage_ready (stage_ready),
    .stage       (stage)
  );

  kms_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .stage_ready (stage_ready),
    .cfg         (cfg),
    .scan_out    (scan_out)
  );

endmodule

// ----- src/kms_in_reg.sv -----
module kms_in_reg (
  input  logic                clk,
  input  logic                rst,
  kms_in_if.sink              scan_in,
  input  logic                stage_ready,
  output kms_pkg::kms_stage_t stage
);
  import kms_pkg::*;

  logic   valid;
  lines_t column_lines;
  logic   take;

  assign scan_in.ready = !valid || stage_ready;
  assign take = scan_in.valid && scan_in.ready;
  assign stage = '{valid: valid, column_lines: column_lines};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (stage_ready) begin
      valid <= 1'b0;
    end
    if (take) begin
      column_lines <= scan_in.column_lines;
    end
  end

endmodule

// ----- src/kms_core.sv -----
module kms_core #(
  parameter int COUNT_WIDTH    = 8,
  parameter int DEBOUNCE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  kms_pkg::kms_stage_t stage,
  output logic                stage_ready,
  kms_cfg_if.sink             cfg,
  kms_out_if.source           scan_out
);
  import kms_pkg::*;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [15:0]               debounce_ticks;
  row_idx_t                  scan_row, scan_row_next;
  phase_t                    scan_phase, scan_phase_next;
  logic [DEBOUNCE_WIDTH-1:0] wait_count, wait_count_next;
  col_idx_t                  held_column, held_column_next;
  ascii_t                    previous_key, previous_key_next;
  logic [COUNT_WIDTH-1:0]    run_length, run_length_next;

  logic                      out_valid;
  lines_t                    row_drive;
  logic                      key_valid, key_valid_next;
  ascii_t                    key_code, key_code_next;
  logic [7:0]                press_count, press_count_next;
  logic                      new_run, new_run_next;

  logic                      fire;
  lines_t                    cols_low;
  logic [DEBOUNCE_WIDTH-1:0] limit;
  ascii_t                    code;

  assign cfg.ready   = 1'b1;
  assign stage_ready = !out_valid || scan_out.ready;
  assign fire        = stage.valid && stage_ready;
  assign cols_low    = ~stage.column_lines;
  assign limit       = DEBOUNCE_WIDTH'(debounce_ticks);
  assign code        = KEY_MAP[{scan_row, held_column}];

  assign scan_out.valid       = out_valid;
  assign scan_out.row_drive   = row_drive;
  assign scan_out.key_valid   = key_valid;
  assign scan_out.key_code    = key_code;
  assign scan_out.press_count = press_count;
  assign scan_out.new_run     = new_run;

  always_comb begin
    scan_row_next     = scan_row;
    scan_phase_next   = scan_phase;
    wait_count_next   = wait_count;
    held_column_next  = held_column;
    previous_key_next = previous_key;
    run_length_next   = run_length;
    key_valid_next    = 1'b0;
    key_code_next     = '0;
    press_count_next  = '0;
    new_run_next      = 1'b0;
    unique case (scan_phase)
      PH_SCAN: begin
        if (cols_low != '0) begin
          held_column_next = first_low(stage.column_lines);
          wait_count_next  = '0;
          scan_phase_next  = PH_DEBOUNCE;
        end else begin
          scan_row_next = scan_row + 2'd1;
        end
      end
      PH_DEBOUNCE: begin
        if (wait_count >= limit) begin
          scan_phase_next = PH_RELEASE;
        end else begin
          wait_count_next = wait_count + 1'b1;
        end
      end
      PH_RELEASE: begin
        if (!cols_low[held_column]) begin
          if (code == previous_key) begin
            if (run_length != COUNT_MAX) begin
              run_length_next = run_length + 1'b1;
            end
          end else begin
            run_length_next = COUNT_WIDTH'(1);
            new_run_next    = 1'b1;
          end
          previous_key_next = code;
          key_valid_next    = 1'b1;
          key_code_next     = code;
          press_count_next  = 8'(run_length_next);
          scan_phase_next   = PH_SCAN;
          scan_row_next     = '0;
        end
      end
      default: begin
        scan_phase_next = PH_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      scan_row       <= '0;
      scan_phase     <= PH_SCAN;
      wait_count     <= '0;
      held_column    <= '0;
      previous_key   <= '0;
      run_length     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        debounce_ticks <= cfg.data;
      end
      if (fire) begin
        scan_row     <= scan_row_next;
        scan_phase   <= scan_phase_next;
        wait_count   <= wait_count_next;
        held_column  <= held_column_next;
        previous_key <= previous_key_next;
        run_length   <= run_length_next;
        out_valid    <= 1'b1;
      end else if (scan_out.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      row_drive   <= 4'(~(4'b0001 << scan_row));
      key_valid   <= key_valid_next;
      key_code    <= key_code_next;
      press_count <= press_count_next;
      new_run     <= new_run_next;
    end
  end

endmodule

// ----- tb/keypad_scan_checker.sv -----
module keypad_scan_checker (
  input  logic clk,
  input  logic rst,
  kms_in_if    scan_in,
  kms_out_if   scan_out,
  kms_cfg_if   cfg,
  output int   failures,
  output int   outstanding
);
  import kms_pkg::*;

  typedef enum logic [1:0] {
    SCANNING,
    DEBOUNCING,
    RELEASE_WAIT,
    PHASE_SPARE
  } scan_phase_t;

  typedef struct packed {
    lines_t     row_drive;
    logic       key_valid;
    ascii_t     key_code;
    logic [7:0] press_count;
    logic       new_run;
  } scan_result_t;

  localparam logic [7:0] KEY_CHARS [16] = '{
    "7", "8", "9", "/",
    "4", "5", "6", "X",
    "1", "2", "3", "-",
    "C", "0", "=", "+"
  };

  scan_phase_t  phase;
  row_idx_t     row;
  col_idx_t     held;
  logic [15:0]  wait_cnt;
  logic [15:0]  debounce;
  ascii_t       last_key;
  logic [7:0]   run;
  scan_result_t expected_scans [$];

  initial begin
    failures = 0;
    outstanding = 0;
  end

  task report(input string msg);
    $display("%0t: %s", $time, msg);
    failures++;
  endtask

  task check_field(input string field, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s mismatch: got %0h, want %0h", field, got, want));
    end
  endtask

  // one scan tick: advance the scanner state and form the result it reports
  task scan_tick(input lines_t lines, output scan_result_t res);
    lines_t lows;
    col_idx_t col;
    ascii_t code;
    lows = ~lines;
    res = '0;
    res.row_drive = ~(4'b0001 << row);
    case (phase)
      SCANNING: begin
        if (lows != 4'b0000) begin
          col = 2'd0;
          for (int i = 3; i >= 0; i--) begin
            if (lows[i]) col = col_idx_t'(i);
          end
          held = col;
          wait_cnt = '0;
          phase = DEBOUNCING;
        end else begin
          row = row + 2'd1;
        end
      end
      DEBOUNCING: begin
        if (wait_cnt >= debounce) phase = RELEASE_WAIT;
        else wait_cnt = wait_cnt + 16'd1;
      end
      RELEASE_WAIT: begin
        if (!lows[held]) begin
          code = KEY_CHARS[{row, held}][6:0];
          if (code == last_key) begin
            if (run != 8'hFF) run = run + 8'd1;
            res.new_run = 1'b0;
          end else begin
            run = 8'd1;
            res.new_run = 1'b1;
          end
          last_key = code;
          res.key_valid = 1'b1;
          res.key_code = code;
          res.press_count = run;
          phase = SCANNING;
          row = 2'd0;
        end
      end
      default: begin
        phase = SCANNING;
      end
    endcase
  endtask

  always @(posedge clk) begin
    scan_result_t want, got;
    if (rst) begin
      phase = SCANNING;
      row = 2'd0;
      held = 2'd0;
      wait_cnt = '0;
      debounce = 16'd10000;
      last_key = '0;
      run = '0;
      expected_scans.delete();
    end else begin
      if (scan_out.valid && scan_out.ready) begin
        got.row_drive = scan_out.row_drive;
        got.key_valid = scan_out.key_valid;
        got.key_code = scan_out.key_code;
        got.press_count = scan_out.press_count;
        got.new_run = scan_out.new_run;
        if (expected_scans.size() == 0) begin
          report($sformatf("unexpected result transaction %0h", got));
        end else begin
          want = expected_scans.pop_front();
          check_field("row_drive", got.row_drive, want.row_drive);
          check_field("key_valid", got.key_valid, want.key_valid);
          check_field("key_code", got.key_code, want.key_code);
          check_field("press_count", got.press_count, want.press_count);
          check_field("new_run", got.new_run, want.new_run);
        end
      end
      if (cfg.valid && cfg.ready) debounce = cfg.data;
      if (scan_in.valid && scan_in.ready) begin
        scan_tick(scan_in.column_lines, want);
        expected_scans.push_back(want);
      end
    end
    outstanding <= expected_scans.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import kms_pkg::*;

  localparam int LIMIT = 600000;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  int   debounce_now = 10000;
  int   sent = 0;
  int   last_row = 0;
  int   last_col = 0;
  bit   calm = 1'b0;
  bit   pressure_go = 1'b0;
  bit   pressure_done = 1'b0;

  kms_in_if  scan_in ();
  kms_out_if scan_out ();
  kms_cfg_if cfg ();

  matrix_keypad_scanner u_top (
    .clk      (clk),
    .rst      (rst),
    .scan_in  (scan_in),
    .scan_out (scan_out),
    .cfg      (cfg)
  );

  keypad_scan_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .scan_in     (scan_in),
    .scan_out    (scan_out),
    .cfg         (cfg),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    scan_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        scan_out.ready <= 1'b0;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
        scan_out.ready <= 1'b1;
      end else begin
        scan_out.ready <= calm || ($urandom_range(99, 0) >= 6);
      end
    end
  end

  task send(input lines_t lines);
    if (!calm && $urandom_range(99, 0) < 6) begin
      scan_in.valid <= 1'b0;
      @(posedge clk);
    end
    scan_in.valid <= 1'b1;
    scan_in.column_lines <= lines;
    @(posedge clk);
    while (!scan_in.ready) @(posedge clk);
    sent++;
  endtask

  task drain;
    scan_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_debounce(input logic [15:0] ticks);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= ticks;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    debounce_now = ticks;
  endtask

  // full press of key (r, c); expects scanning at the first row
  task key_session(input int r, input int c, input int hold);
    lines_t lines;
    repeat (r) send(4'hF);
    lines = 4'($urandom);
    lines[c] = 1'b0;
    for (int k = 0; k < c; k++) lines[k] = 1'b1;
    send(lines);
    repeat (debounce_now + 1) send(4'($urandom));
    repeat (hold) begin
      lines = 4'($urandom);
      lines[c] = 1'b0;
      send(lines);
    end
    lines = 4'($urandom);
    lines[c] = 1'b1;
    send(lines);
    last_row = r;
    last_col = c;
  endtask

  // press on the first row; the debounce value changes partway through the wait
  task key_session_split(input int c, input int pre, input logic [15:0] ticks);
    lines_t lines;
    lines = 4'($urandom);
    lines[c] = 1'b0;
    for (int k = 0; k < c; k++) lines[k] = 1'b1;
    send(lines);
    repeat (pre) send(4'($urandom));
    write_debounce(ticks);
    repeat ((ticks >= pre) ? (ticks - pre + 1) : 1) send(4'($urandom));
    lines = 4'($urandom);
    lines[c] = 1'b1;
    send(lines);
    last_row = 0;
    last_col = c;
  endtask

  // random column noise, then a forced report to get back to the first row
  task scramble;
    repeat ($urandom_range(8, 1)) send(4'($urandom));
    repeat (debounce_now + 2) send(4'hF);
    send(4'h0);
    repeat (debounce_now + 2) send(4'hF);
  endtask

  task random_phase(input int items);
    int stop;
    stop = sent + items;
    while (sent < stop) begin
      if ($urandom_range(99, 0) < 12) begin
        scramble();
      end else begin
        if ($urandom_range(1, 0) == 0) begin
          last_row = $urandom_range(3, 0);
          last_col = $urandom_range(3, 0);
        end
        key_session(last_row, last_col, $urandom_range(3, 0));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    scan_in.valid <= 1'b0;
    scan_in.column_lines <= 4'hF;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset debounce value, first key after reset
    key_session_split(0, 24, 16'd30);

    write_debounce(16'd0);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) key_session(r, c, 1);
    end
    key_session(3, 3, 2);

    write_debounce(16'hFFFF);
    key_session_split(2, 40, 16'd0);

    // run count saturation
    write_debounce(16'd0);
    repeat (258) key_session(0, 1, 0);

    write_debounce(16'd1);
    pressure_go <= 1'b1;
    random_phase(160);
    write_debounce(16'($urandom_range(9, 2)));
    random_phase(160);
    write_debounce(16'd0);
    calm <= 1'b1;
    random_phase(160);
    calm <= 1'b0;
    write_debounce(16'd3);
    random_phase(160);
    write_debounce(16'($urandom_range(15, 0)));
    random_phase(160);
    write_debounce(16'd5);
    random_phase(160);

    drain();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/kms_pkg.sv
src/kms_if.sv
src/kms_in_reg.sv
src/kms_core.sv
src/matrix_keypad_scanner.sv
tb/keypad_scan_checker.sv
tb/testbench.sv
